>>> rtl/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared widths, codes and types of the positional circular list.
// ----------------------------------------------------------------------------
package pcl_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 7;
   localparam int FUNC_W   = 2;
   localparam int STAT_W   = 2;
   localparam int LEN_W    = 7;
   // count holds 0..CAPACITY
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   // width used for all position / count compares
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   // read-out OR tree: cells per group
   localparam int GRP      = 8;
   localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

   localparam logic [FUNC_W-1:0] OP_READ   = 2'd0;
   localparam logic [FUNC_W-1:0] OP_INSERT = 2'd1;
   localparam logic [FUNC_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // command broadcast to every cell
   typedef struct packed {
      logic              load;    // request accepted this cycle
      logic              rd_en;   // capture the element at rd_idx
      logic              ins_en;  // shift up from pos, write value at pos
      logic              del_en;  // shift down from pos
      logic [CMP_W-1:0]  pos;
      logic [CMP_W-1:0]  rd_idx;
      logic [DATA_W-1:0] value;
   } pcl_ctl_type;

   // result fields carried alongside the read-out tree
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [LEN_W-1:0]  length;
      logic              empty;
   } pcl_meta_type;

endpackage

>>> rtl/pcl_cell.sv
// ----------------------------------------------------------------------------
// pcl_cell
// One storage cell of the list: holds one element, shifts with its
// neighbors on insert and delete, and captures its value for read-out.
// ----------------------------------------------------------------------------
module pcl_cell (
   input  logic                       clock,
   input  pcl_pkg::pcl_ctl_type       ctl,
   input  logic [pcl_pkg::CMP_W-1:0]  index,
   input  logic [pcl_pkg::DATA_W-1:0] left_value,
   input  logic [pcl_pkg::DATA_W-1:0] right_value,
   output logic [pcl_pkg::DATA_W-1:0] value,
   output logic [pcl_pkg::DATA_W-1:0] tap
);
   import pcl_pkg::*;

   logic [DATA_W-1:0] value_ff, value_in;
   logic [DATA_W-1:0] tap_ff, tap_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.ins_en) begin
         if (index > ctl.pos) begin
            value_in = left_value;
         end else if (index == ctl.pos) begin
            value_in = ctl.value;
         end
      end else if (ctl.del_en) begin
         if (index >= ctl.pos) begin
            value_in = right_value;
         end
      end
   end

   // tap sees the value before this request's shift
   always_comb begin
      tap_in = tap_ff;
      if (ctl.load) begin
         tap_in = (ctl.rd_en && index == ctl.rd_idx) ? value_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      tap_ff   <= tap_in;
   end

   assign value = value_ff;
   assign tap   = tap_ff;

endmodule

>>> rtl/pcl_decode.sv
// ----------------------------------------------------------------------------
// pcl_decode
// Checks a request against the current count and builds the cell command,
// the status and the count after the operation.
// ----------------------------------------------------------------------------
module pcl_decode (
   input  logic                       accept,
   input  logic [pcl_pkg::FUNC_W-1:0] func,
   input  logic [pcl_pkg::POS_W-1:0]  position,
   input  logic [pcl_pkg::DATA_W-1:0] value,
   input  logic [pcl_pkg::CNT_W-1:0]  count,
   output pcl_pkg::pcl_ctl_type       ctl,
   output logic [pcl_pkg::STAT_W-1:0] status,
   output logic [pcl_pkg::CNT_W-1:0]  count_next
);
   import pcl_pkg::*;

   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] cnt_x;
   logic             cnt_zero;
   logic             full;
   logic             rd_ok;
   logic             ins_ok;
   logic             del_ok;

   assign pos_x    = CMP_W'(position);
   assign cnt_x    = CMP_W'(count);
   assign cnt_zero = (count == '0);
   assign full     = (cnt_x >= CMP_W'(CAPACITY));

   always_comb begin
      rd_ok  = 1'b0;
      ins_ok = 1'b0;
      del_ok = 1'b0;
      status = ST_RANGE;
      case (func)
         OP_READ: begin
            if (!cnt_zero && pos_x <= cnt_x) begin
               rd_ok  = 1'b1;
               status = ST_OK;
            end
         end
         OP_INSERT: begin
            if (pos_x > cnt_x) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               ins_ok = 1'b1;
               status = ST_OK;
            end
         end
         OP_DELETE: begin
            if (!cnt_zero && pos_x < cnt_x) begin
               del_ok = 1'b1;
               status = ST_OK;
            end
         end
         default: status = ST_RANGE;
      endcase
   end

   always_comb begin
      ctl.load   = accept;
      ctl.rd_en  = rd_ok | del_ok;
      ctl.ins_en = accept & ins_ok;
      ctl.del_en = accept & del_ok;
      ctl.pos    = pos_x;
      // read at the length wraps to the head
      ctl.rd_idx = (rd_ok && pos_x == cnt_x) ? '0 : pos_x;
      ctl.value  = value;
   end

   always_comb begin
      count_next = count;
      if (ins_ok) begin
         count_next = count + CNT_W'(1);
      end else if (del_ok) begin
         count_next = count - CNT_W'(1);
      end
   end

endmodule

>>> rtl/positional_circular_list_core.sv
// ----------------------------------------------------------------------------
// positional_circular_list_core
// Bounded ordered list of signed 32-bit values kept in a row of cells;
// read, insert-before and delete at a position, read wraps at the length.
// ----------------------------------------------------------------------------
//  channel   | ports                                  | direction
//  ----------+----------------------------------------+----------
//  request   | req_valid req_stall req_func           | in
//            | req_position req_value                 |
//  response  | rsp_valid rsp_stall rsp_data rsp_status| out
//            | rsp_length rsp_empty_res               |
//
// A request passes the cell tap register, the registered group OR and the
// response register; a new one is taken once the tap and group stages are empty.
// On an accepted insert or delete, the cells from the position up shift in the cycle it is accepted.
// Reset clears the count and the valid flags; cell contents are not reset.
// A stalled response holds; the next request is taken while it waits.
// ----------------------------------------------------------------------------
module positional_circular_list_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [pcl_pkg::FUNC_W-1:0] req_func,
   input  logic [pcl_pkg::POS_W-1:0]  req_position,
   input  logic signed [pcl_pkg::DATA_W-1:0] req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [pcl_pkg::DATA_W-1:0] rsp_data,
   output logic [pcl_pkg::STAT_W-1:0] rsp_status,
   output logic [pcl_pkg::LEN_W-1:0]  rsp_length,
   output logic                       rsp_empty_res
);
   import pcl_pkg::*;

   logic                accept;
   pcl_ctl_type         ctl;
   logic [STAT_W-1:0]   status;
   logic [CNT_W-1:0]    count_next;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                tap_vld_ff, tap_vld_in;
   logic                grp_vld_ff, grp_vld_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic                advance;

   pcl_meta_type        meta_now;
   pcl_meta_type        meta1_ff, meta1_in;
   pcl_meta_type        meta2_ff, meta2_in;
   pcl_meta_type        rsp_meta_ff, rsp_meta_in;

   logic [DATA_W-1:0]   cell_value [CAPACITY];
   logic [DATA_W-1:0]   cell_tap   [CAPACITY];
   logic [DATA_W-1:0]   grp_or     [NGRP];
   logic [DATA_W-1:0]   grp_ff     [NGRP];
   logic [DATA_W-1:0]   grp_in     [NGRP];
   logic [DATA_W-1:0]   all_or;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   assign req_stall = tap_vld_ff | grp_vld_ff;
   assign accept    = req_valid & ~req_stall;
   assign advance   = grp_vld_ff & (~rsp_vld_ff | ~rsp_stall);

   pcl_decode u_decode (
      .accept     (accept),
      .func       (req_func),
      .position   (req_position),
      .value      (req_value),
      .count      (count_ff),
      .ctl        (ctl),
      .status     (status),
      .count_next (count_next)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_v;
      logic [DATA_W-1:0] right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_value[i+1];
      end
      pcl_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .index       (CMP_W'(i)),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_value[i]),
         .tap         (cell_tap[i])
      );
   end

   // first level of the read-out tree: groups of GRP taps
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_or[g] = '0;
         for (int k = 0; k < GRP; k++) begin
            if (g * GRP + k < CAPACITY) begin
               grp_or[g] = grp_or[g] | cell_tap[g * GRP + k];
            end
         end
      end
   end

   always_comb begin
      all_or = '0;
      for (int g = 0; g < NGRP; g++) begin
         all_or = all_or | grp_ff[g];
      end
   end

   always_comb begin
      meta_now.status = status;
      meta_now.length = LEN_W'(count_next);
      meta_now.empty  = (count_next == '0);
   end

   always_comb begin
      count_in    = accept ? count_next : count_ff;
      tap_vld_in  = accept;
      grp_vld_in  = tap_vld_ff | (grp_vld_ff & ~advance);
      rsp_vld_in  = advance | (rsp_vld_ff & rsp_stall);
      meta1_in    = accept ? meta_now : meta1_ff;
      meta2_in    = tap_vld_ff ? meta1_ff : meta2_ff;
      rsp_meta_in = advance ? meta2_ff : rsp_meta_ff;
      rsp_data_in = advance ? all_or : rsp_data_ff;
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = tap_vld_ff ? grp_or[g] : grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         tap_vld_ff <= 1'b0;
         grp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         tap_vld_ff <= tap_vld_in;
         grp_vld_ff <= grp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      meta1_ff    <= meta1_in;
      meta2_ff    <= meta2_in;
      rsp_meta_ff <= rsp_meta_in;
      rsp_data_ff <= rsp_data_in;
      for (int g = 0; g < NGRP; g++) begin
         grp_ff[g] <= grp_in[g];
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_status    = rsp_meta_ff.status;
   assign rsp_length    = rsp_meta_ff.length;
   assign rsp_empty_res = rsp_meta_ff.empty;

endmodule
